// File: hdl/multilevel_feedback_queue_defines.svh
// Assertion macros shared by the scheduler's checker.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef MULTILEVEL_FEEDBACK_QUEUE_DEFINES_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MLFQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MLFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/mlfq_pkg.sv
// Shared types and constants for the multilevel feedback queue scheduler.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package mlfq_pkg;

    localparam int MLFQ_MAX_ITEMS   = 16;
    localparam int MLFQ_ID_BITS     = 8;
    localparam int MLFQ_USER_LEVELS = 3;

    // One real-time queue plus up to three user levels.
    localparam int NUM_QUEUES = 4;

    localparam int              CAP_W     = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Configuration port: one 32-bit register, index taken above the byte offset.
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_INDEX_LSB = 2;
    localparam logic [CFG_ADDR_W-CFG_INDEX_LSB-1:0] REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        ACT_INSERT   = 2'd0,
        ACT_FEEDBACK = 2'd1,
        ACT_PICK     = 2'd2,
        ACT_NOP      = 2'd3
    } action_t;

endpackage

`default_nettype wire

// File: hdl/multilevel_feedback_queue.sv
// Multilevel feedback queue scheduler: input word register, decision logic,
// result word register. Depends on mlfq_pkg.
//
// Usage: a command word (action, item_id, is_user, level) enters on the item
// channel when item_valid is high and item_stall is low. Every accepted word
// gives exactly one result word on the result channel, taken when
// result_valid is high and result_stall is low.
// An accepted word is held in the input register and moves on into the result
// register whenever the result word ahead of it is not stalled (one input
// register, one result register).
// Throughput: one word per cycle unless the result word is stalled; each of the
// four queue memories has one write and one registered read per cycle, and the
// read always fetches the head entry for the state the current word leaves behind.
// Reset empties all four queues, clears the shared count and sets the
// capacity register to 16. Queue memories are not cleared; an entry is only
// read after it has been written.
// When the receiver stalls, the result word holds; one more word may enter the
// input register, then item_stall is raised until the result is taken. The user
// must write capacity over the APB port only while idle; the block does not check.
`default_nettype none

module multilevel_feedback_queue
    import mlfq_pkg::*;
#(
    parameter int MAX_ITEMS   = MLFQ_MAX_ITEMS,
    parameter int ID_BITS     = MLFQ_ID_BITS,
    parameter int USER_LEVELS = MLFQ_USER_LEVELS
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    // configuration port
    input  wire logic                                    psel,
    input  wire logic                                    penable,
    input  wire logic                                    pwrite,
    input  wire logic [CFG_ADDR_W-1:0]                   paddr,
    input  wire logic [CFG_DATA_W-1:0]                   pwdata,
    output logic      [CFG_DATA_W-1:0]                   prdata,
    output logic                                         pready,
    // item channel
    input  wire logic                                    item_valid,
    output logic                                         item_stall,
    input  wire logic [1:0]                              action,
    input  wire logic [ID_BITS-1:0]                      item_id,
    input  wire logic                                    is_user,
    input  wire logic [1:0]                              level,
    // result channel
    output logic                                         result_valid,
    input  wire logic                                    result_stall,
    output logic                                         picked_valid,
    output logic      [ID_BITS-1:0]                      picked_id,
    output logic                                         picked_is_user,
    output logic      [1:0]                              picked_level,
    output logic      [1:0]                              stored_level,
    output logic                                         dropped,
    output logic      [$clog2(MAX_ITEMS+1)-1:0]          occupancy,
    output logic                                         all_empty,
    output logic                                         at_capacity
);

    localparam int PTR_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int IDX_W = CFG_ADDR_W - CFG_INDEX_LSB;
    localparam logic [1:0] LOWEST_LVL = 2'((USER_LEVELS < 3) ? USER_LEVELS : 3);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(MAX_ITEMS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_ITEMS);
    localparam logic [CNT_W:0]   WRAP_SUM  = (CNT_W + 1)'(MAX_ITEMS);

    // ---------------- configuration ----------------
    logic [CAP_W-1:0] capacity_reg;
    logic [IDX_W-1:0] cfg_index;
    logic             cfg_write;

    assign cfg_index = paddr[CFG_ADDR_W-1:CFG_INDEX_LSB];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_write && (cfg_index == REG_CAPACITY)) begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (cfg_index == REG_CAPACITY) begin
            prdata[CAP_W-1:0] = capacity_reg;
        end
    end

    // ---------------- input word register ----------------
    logic               s1_valid_reg;
    logic               s1_valid_next;
    action_t            s1_action_reg;
    logic [ID_BITS-1:0] s1_id_reg;
    logic               s1_user_reg;
    logic [1:0]         s1_level_reg;
    logic               s1_move;
    logic               item_accept;

    // The input word moves on whenever the result register is free or being read.
    assign s1_move     = s1_valid_reg && !(result_valid && result_stall);
    assign item_stall  = s1_valid_reg && result_valid && result_stall;
    assign item_accept = item_valid && !item_stall;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (item_accept) begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end
        else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (item_accept) begin
            s1_action_reg <= action_t'(action);
            s1_id_reg     <= item_id;
            s1_user_reg   <= is_user;
            s1_level_reg  <= level;
        end
    end

    // ---------------- queue state ----------------
    logic [PTR_W-1:0]   head_reg  [NUM_QUEUES];
    logic [PTR_W-1:0]   head_next [NUM_QUEUES];
    logic [CNT_W-1:0]   fill_reg  [NUM_QUEUES];
    logic [CNT_W-1:0]   fill_next [NUM_QUEUES];
    logic [CNT_W-1:0]   total_reg;
    logic [CNT_W-1:0]   total_next;
    logic [ID_BITS-1:0] fifo_mem      [NUM_QUEUES][MAX_ITEMS];
    logic [ID_BITS-1:0] head_word_reg [NUM_QUEUES];

    // decision logic
    logic [1:0]       lvl_fixed;
    logic [1:0]       store_q;
    logic             store_full;
    logic             store_drop;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic [CNT_W:0]   wr_sum;
    logic             pick_found;
    logic [1:0]       pick_q;

    always_comb begin
        // A level of zero counts as the top level; deeper levels clamp to the lowest.
        lvl_fixed = s1_level_reg;
        if (lvl_fixed == 2'd0) begin
            lvl_fixed = 2'd1;
        end
        if (lvl_fixed > LOWEST_LVL) begin
            lvl_fixed = LOWEST_LVL;
        end

        store_q = s1_user_reg ? lvl_fixed : 2'd0;
        if ((s1_action_reg == ACT_FEEDBACK) && s1_user_reg && (store_q < LOWEST_LVL)) begin
            store_q = store_q + 2'd1;
        end

        store_full = (total_reg >= FULL_CNT);
        // The capacity test covers inserts only, by equality, so feedback can push the count past it.
        store_drop = store_full ||
                     ((s1_action_reg == ACT_INSERT) &&
                      (CMP_W'(total_reg) == CMP_W'(capacity_reg)));

        wr_sum = (CNT_W + 1)'(head_reg[store_q]) + (CNT_W + 1)'(fill_reg[store_q]);
        if (wr_sum >= WRAP_SUM) begin
            wr_sum = wr_sum - WRAP_SUM;
        end
        wr_addr = wr_sum[PTR_W-1:0];

        pick_found = 1'b0;
        pick_q     = 2'd0;
        for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
            if (fill_reg[i] != '0) begin
                pick_found = 1'b1;
                pick_q     = 2'(i);
            end
        end

        wr_en      = 1'b0;
        total_next = total_reg;
        for (int i = 0; i < NUM_QUEUES; i++) begin
            head_next[i] = head_reg[i];
            fill_next[i] = fill_reg[i];
        end

        if (s1_move) begin
            unique case (s1_action_reg)
                ACT_INSERT, ACT_FEEDBACK: begin
                    if (!store_drop) begin
                        wr_en              = 1'b1;
                        fill_next[store_q] = fill_reg[store_q] + CNT_W'(1);
                        total_next         = total_reg + CNT_W'(1);
                    end
                end
                ACT_PICK: begin
                    if (pick_found) begin
                        head_next[pick_q] = (head_reg[pick_q] == LAST_PTR) ?
                                            '0 : head_reg[pick_q] + PTR_W'(1);
                        fill_next[pick_q] = fill_reg[pick_q] - CNT_W'(1);
                        total_next        = total_reg - CNT_W'(1);
                    end
                end
                ACT_NOP: begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            total_reg <= '0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end
        else begin
            total_reg <= total_next;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                head_reg[i] <= head_next[i];
                fill_reg[i] <= fill_next[i];
            end
        end
    end

    // Queue memories: one write port, one registered read port per queue. The read
    // follows the next head pointer so head_word_reg always holds the current head,
    // with the incoming word forwarded when it lands on that entry.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            fifo_mem[store_q][wr_addr] <= s1_id_reg;
        end
        for (int i = 0; i < NUM_QUEUES; i++) begin
            if (wr_en && (store_q == 2'(i)) && (wr_addr == head_next[i])) begin
                head_word_reg[i] <= s1_id_reg;
            end
            else begin
                head_word_reg[i] <= fifo_mem[i][head_next[i]];
            end
        end
    end

    // ---------------- result word register ----------------
    logic               result_valid_reg;
    logic               result_valid_next;
    logic               picked_valid_reg;
    logic [ID_BITS-1:0] picked_id_reg;
    logic               picked_is_user_reg;
    logic [1:0]         picked_level_reg;
    logic [1:0]         stored_level_reg;
    logic               dropped_reg;
    logic [CNT_W-1:0]   occupancy_reg;
    logic               all_empty_reg;
    logic               at_capacity_reg;
    logic               is_pick;
    logic               is_store;

    assign is_pick  = (s1_action_reg == ACT_PICK) && pick_found;
    assign is_store = (s1_action_reg == ACT_INSERT) || (s1_action_reg == ACT_FEEDBACK);

    always_comb begin
        result_valid_next = result_valid_reg;
        if (s1_move) begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall) begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            result_valid_reg <= 1'b0;
        end
        else begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (s1_move) begin
            picked_valid_reg   <= is_pick;
            picked_id_reg      <= is_pick ? head_word_reg[pick_q] : '0;
            picked_is_user_reg <= is_pick && (pick_q != 2'd0);
            picked_level_reg   <= is_pick ? pick_q : 2'd0;
            stored_level_reg   <= (is_store && !store_drop) ? store_q : 2'd0;
            dropped_reg        <= is_store && store_drop;
            occupancy_reg      <= total_next;
            all_empty_reg      <= (total_next == '0);
            at_capacity_reg    <= (CMP_W'(total_next) >= CMP_W'(capacity_reg));
        end
    end

    assign result_valid   = result_valid_reg;
    assign picked_valid   = picked_valid_reg;
    assign picked_id      = picked_id_reg;
    assign picked_is_user = picked_is_user_reg;
    assign picked_level   = picked_level_reg;
    assign stored_level   = stored_level_reg;
    assign dropped        = dropped_reg;
    assign occupancy      = occupancy_reg;
    assign all_empty      = all_empty_reg;
    assign at_capacity    = at_capacity_reg;

endmodule

`default_nettype wire

// File: hdl/mlfq_checker.sv
// Port-level checker for the multilevel feedback queue scheduler, with its bind.
// Depends on mlfq_pkg and multilevel_feedback_queue_defines.svh.
`default_nettype none

`include "multilevel_feedback_queue_defines.svh"

module mlfq_checker
    import mlfq_pkg::*;
#(
    parameter int MAX_ITEMS = MLFQ_MAX_ITEMS,
    parameter int ID_BITS   = MLFQ_ID_BITS
) (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           result_valid,
    input wire logic                           result_stall,
    input wire logic                           picked_valid,
    input wire logic [ID_BITS-1:0]             picked_id,
    input wire logic                           picked_is_user,
    input wire logic [1:0]                     picked_level,
    input wire logic [1:0]                     stored_level,
    input wire logic                           dropped,
    input wire logic [$clog2(MAX_ITEMS+1)-1:0] occupancy,
    input wire logic                           all_empty
);

    // A user item always carries a nonzero level; a real-time item level zero.
    `MLFQ_ASSERT_SAME(a_level_matches_kind, result_valid, picked_is_user == (picked_level != 2'd0), "picked level disagrees with item kind")

    // A word that picked an item stored nothing and dropped nothing.
    `MLFQ_ASSERT_SAME(a_pick_excludes_store, result_valid && picked_valid, !dropped && (stored_level == 2'd0), "pick word also reports a store")

    `MLFQ_ASSERT_SAME(a_empty_flag, result_valid, all_empty == (occupancy == '0), "empty flag disagrees with occupancy")

    `MLFQ_ASSERT_NEXT(a_stall_holds, result_valid && result_stall, result_valid && $stable(picked_id) && $stable(occupancy), "stalled result word changed")

endmodule

bind multilevel_feedback_queue mlfq_checker #(
    .MAX_ITEMS (MAX_ITEMS),
    .ID_BITS   (ID_BITS)
) u_mlfq_checker (.*);

`default_nettype wire
